// File: rtl/udrb_pkg.sv
// Shared types and codes for the UART dual ring buffer.
// Used by udrb_ctrl, udrb_datapath and uart_dual_ring_buffer; depends on nothing.
package udrb_pkg;

   // Default buffer depths, handed to the top-level parameters.
   localparam int TX_DEPTH_DEF = 64;
   localparam int RX_DEPTH_DEF = 64;

   // Field widths fixed by the interface.
   localparam int FUNC_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int PIDX_W   = 6;
   localparam int STATUS_W = 3;
   localparam int FILL_W   = 7;

   // Operation codes on req_func.
   localparam logic [FUNC_W-1:0] FUNC_PUT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_TX_RDY  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RX_LINE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_GET     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PREVIEW = 3'd4;

   // Status codes on rsp_status.
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_TX_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RX_DROP  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RX_EMPTY = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_TX_IDLE  = 3'd4;

   // Controller states.
   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;  // write one zero entry of the receive store
      logic capture;     // latch the request word
      logic execute;     // carry out the latched operation
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // the clearing pass is at its last entry
   } stat_type;

endpackage

// File: rtl/uart_dual_ring_buffer.sv
// UART dual ring buffer: transmit and receive byte FIFOs behind one command port.
// Each accepted word is captured, then executed (one store access and pointer update),
// and its result is then strobed; the next word may be captured while a result is shown.
// Reset: synchronous; after reset the receive store is cleared, one entry a cycle,
// until every entry is zero, with busy high. Results are strobed and cannot be stalled.
// Depends on udrb_pkg, udrb_ctrl and udrb_datapath.
module uart_dual_ring_buffer
   import udrb_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [PIDX_W-1:0]   req_preview_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic                rsp_data_valid,
   output logic [FILL_W-1:0]   rsp_tx_fill,
   output logic [FILL_W-1:0]   rsp_rx_fill,
   output logic                rsp_rx_ready,
   output logic                rsp_tx_irq_on
);

   // The controller sequences each word through a capture cycle, an execute
   // cycle in which the stores are accessed and the pointers move, and a
   // result cycle. The next word can be captured during the result cycle,
   // because the result registers only change at the end of an execute cycle.
   cmd_type  cmd;
   stat_type stat;

   udrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds both stores as memories with registered reads. The
   // receive store is zeroed by the clearing pass, so a preview of an entry
   // never written returns zero; the transmit store's data is only shown after
   // it was written and needs no clearing.
   udrb_datapath #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_preview_index (req_preview_index),
      .rsp_status        (rsp_status),
      .rsp_data_out      (rsp_data_out),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_tx_fill       (rsp_tx_fill),
      .rsp_rx_fill       (rsp_rx_fill),
      .rsp_rx_ready      (rsp_rx_ready),
      .rsp_tx_irq_on     (rsp_tx_irq_on)
   );

endmodule

// File: rtl/udrb_ctrl.sv
// Controller state machine of the UART dual ring buffer.
// Depends on udrb_pkg; drives the command struct of udrb_datapath.
module udrb_ctrl
   import udrb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     rsp_valid,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff;
   state_type state_in;

   // A new word may be taken while the previous result is on the ports.
   assign busy      = !((state_ff == S_IDLE) || (state_ff == S_RESP));
   assign rsp_valid = (state_ff == S_RESP);

   assign cmd.capture    = start && !busy;
   assign cmd.execute    = (state_ff == S_EXEC);
   assign cmd.clear_step = (state_ff == S_CLEAR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = cmd.capture ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // A result always directly follows an execute cycle.
   a_resp_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> ($past(state_ff) == S_EXEC))
      else $error("result shown without a preceding execute cycle");

   // Every captured word is executed in the next cycle.
   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("captured word was not executed");

endmodule

// File: rtl/udrb_datapath.sv
// Datapath of the UART dual ring buffer: both stores, pointers, counts and result registers.
// Depends on udrb_pkg; commanded by udrb_ctrl.
module udrb_datapath
   import udrb_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [PIDX_W-1:0]   req_preview_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic                rsp_data_valid,
   output logic [FILL_W-1:0]   rsp_tx_fill,
   output logic [FILL_W-1:0]   rsp_rx_fill,
   output logic                rsp_rx_ready,
   output logic                rsp_tx_irq_on
);

   localparam int TX_AW    = $clog2(TX_DEPTH);
   localparam int RX_AW    = $clog2(RX_DEPTH);
   localparam int TX_CW    = $clog2(TX_DEPTH + 1);
   localparam int RX_CW    = $clog2(RX_DEPTH + 1);
   localparam int PIDX_NUM = 2 ** PIDX_W;

   // Captured request word.
   logic [FUNC_W-1:0] func_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [PIDX_W-1:0] pidx_ff;

   // Ring state.
   logic [TX_AW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic [TX_CW-1:0] tx_cnt_ff, tx_cnt_in;
   logic [RX_AW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic [RX_CW-1:0] rx_cnt_ff, rx_cnt_in;
   logic             irq_ff, irq_in;
   logic [RX_AW-1:0] clr_ff;

   // Result registers.
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                dv_ff, dv_in;
   logic                src_tx_ff, src_tx_in;
   logic [BYTE_W-1:0]   tx_rd_ff, rx_rd_ff;

   // Stores.
   logic [BYTE_W-1:0] tx_mem_ff [TX_DEPTH];
   logic [BYTE_W-1:0] rx_mem_ff [RX_DEPTH];

   logic              tx_we, rx_op_we, rx_we;
   logic [RX_AW-1:0]  rx_waddr, rx_raddr, prev_addr;
   logic [BYTE_W-1:0] rx_wdata;
   logic [RX_AW:0]    prev_sum;
   logic [RX_AW-1:0]  off_mod_tbl [PIDX_NUM];

   logic tx_full, tx_empty, rx_full, rx_empty;

   assign tx_full  = (tx_cnt_ff == TX_CW'(TX_DEPTH));
   assign tx_empty = (tx_cnt_ff == '0);
   assign rx_full  = (rx_cnt_ff == RX_CW'(RX_DEPTH));
   assign rx_empty = (rx_cnt_ff == '0);

   // Offset reduced modulo the receive depth, built at elaboration.
   for (genvar g = 0; g < PIDX_NUM; g++) begin : g_off_mod
      assign off_mod_tbl[g] = RX_AW'(g % RX_DEPTH);
   end

   // Both terms are below the depth, so one conditional subtract wraps the sum.
   assign prev_sum  = {1'b0, rx_rp_ff} + {1'b0, off_mod_tbl[pidx_ff]};
   assign prev_addr = (prev_sum >= (RX_AW + 1)'(RX_DEPTH))
                      ? RX_AW'(prev_sum - (RX_AW + 1)'(RX_DEPTH))
                      : prev_sum[RX_AW-1:0];
   assign rx_raddr  = (func_ff == FUNC_PREVIEW) ? prev_addr : rx_rp_ff;

   always_comb begin
      tx_wp_in  = tx_wp_ff;
      tx_rp_in  = tx_rp_ff;
      tx_cnt_in = tx_cnt_ff;
      rx_wp_in  = rx_wp_ff;
      rx_rp_in  = rx_rp_ff;
      rx_cnt_in = rx_cnt_ff;
      irq_in    = irq_ff;
      status_in = STAT_OK;
      dv_in     = 1'b0;
      src_tx_in = 1'b0;
      tx_we     = 1'b0;
      rx_op_we  = 1'b0;
      if (cmd.execute) begin
         unique case (func_ff)
            FUNC_PUT: begin
               if (tx_full) begin
                  status_in = STAT_TX_FULL;
               end else begin
                  tx_we     = 1'b1;
                  tx_wp_in  = (tx_wp_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp_ff + 1'b1;
                  tx_cnt_in = tx_cnt_ff + 1'b1;
                  irq_in    = 1'b1;
               end
            end
            FUNC_TX_RDY: begin
               if (tx_empty) begin
                  irq_in    = 1'b0;
                  status_in = STAT_TX_IDLE;
               end else begin
                  dv_in     = 1'b1;
                  src_tx_in = 1'b1;
                  tx_rp_in  = (tx_rp_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rp_ff + 1'b1;
                  tx_cnt_in = tx_cnt_ff - 1'b1;
               end
            end
            FUNC_RX_LINE: begin
               if (rx_full) begin
                  status_in = STAT_RX_DROP;
               end else begin
                  rx_op_we  = 1'b1;
                  rx_wp_in  = (rx_wp_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wp_ff + 1'b1;
                  rx_cnt_in = rx_cnt_ff + 1'b1;
               end
            end
            FUNC_GET: begin
               if (rx_empty) begin
                  status_in = STAT_RX_EMPTY;
               end else begin
                  dv_in     = 1'b1;
                  rx_rp_in  = (rx_rp_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rp_ff + 1'b1;
                  rx_cnt_in = rx_cnt_ff - 1'b1;
               end
            end
            FUNC_PREVIEW: begin
               dv_in = 1'b1;
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   // The clearing pass after reset shares the receive write port.
   assign rx_we    = rx_op_we || cmd.clear_step;
   assign rx_waddr = cmd.clear_step ? clr_ff : rx_wp_ff;
   assign rx_wdata = cmd.clear_step ? '0 : byte_ff;
   assign stat.clear_last = (clr_ff == RX_AW'(RX_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem_ff[tx_wp_ff] <= byte_ff;
      end
      if (cmd.execute) begin
         tx_rd_ff <= tx_mem_ff[tx_rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem_ff[rx_waddr] <= rx_wdata;
      end
      if (cmd.execute) begin
         rx_rd_ff <= rx_mem_ff[rx_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         byte_ff <= req_data_byte;
         pidx_ff <= req_preview_index;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         src_tx_ff <= src_tx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wp_ff  <= '0;
         tx_rp_ff  <= '0;
         tx_cnt_ff <= '0;
         rx_wp_ff  <= '0;
         rx_rp_ff  <= '0;
         rx_cnt_ff <= '0;
         irq_ff    <= 1'b0;
         dv_ff     <= 1'b0;
         clr_ff    <= '0;
      end else begin
         tx_wp_ff  <= tx_wp_in;
         tx_rp_ff  <= tx_rp_in;
         tx_cnt_ff <= tx_cnt_in;
         rx_wp_ff  <= rx_wp_in;
         rx_rp_ff  <= rx_rp_in;
         rx_cnt_ff <= rx_cnt_in;
         irq_ff    <= irq_in;
         if (cmd.execute) begin
            dv_ff <= dv_in;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_data_valid = dv_ff;
   assign rsp_data_out   = dv_ff ? (src_tx_ff ? tx_rd_ff : rx_rd_ff) : '0;
   assign rsp_tx_fill    = FILL_W'(tx_cnt_ff);
   assign rsp_rx_fill    = FILL_W'(rx_cnt_ff);
   assign rsp_rx_ready   = !rx_empty;
   assign rsp_tx_irq_on  = irq_ff;

   a_tx_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      tx_cnt_ff <= TX_CW'(TX_DEPTH))
      else $error("transmit count above depth");

   a_rx_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rx_cnt_ff <= RX_CW'(RX_DEPTH))
      else $error("receive count above depth");

   a_put_sets_irq: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && (func_ff == FUNC_PUT) && !tx_full) |=> irq_ff)
      else $error("successful put did not set the interrupt enable");

endmodule
